// ----- hdl/kvbrd_pkg.sv -----
// Shared beat types and header constants for the binary response deframer.
package kvbrd_pkg;

	// Byte roles, also used as the parse phase codes.
	localparam logic [1:0] SEG_HEADER = 2'd0;
	localparam logic [1:0] SEG_EXTRAS = 2'd1;
	localparam logic [1:0] SEG_KEY    = 2'd2;
	localparam logic [1:0] SEG_VALUE  = 2'd3;

	localparam logic [7:0] RESPONSE_MAGIC = 8'h81;

	// Header byte positions.
	localparam logic [4:0] HDR_MAGIC   = 5'd0;
	localparam logic [4:0] HDR_KEY_HI  = 5'd2;
	localparam logic [4:0] HDR_KEY_LO  = 5'd3;
	localparam logic [4:0] HDR_EXTRAS  = 5'd4;
	localparam logic [4:0] HDR_BODY_HI = 5'd8;
	localparam logic [4:0] HDR_BODY_LO = 5'd11;
	localparam logic [4:0] HDR_CAS_HI  = 5'd16;
	localparam logic [4:0] HDR_LAST    = 5'd23;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} stream_beat_t;

	typedef struct packed {
		logic [1:0]  segment;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic        truncated;
		logic        length_error;
		logic        magic_bad;
		logic [15:0] key_size;
		logic [7:0]  extras_size;
		logic [31:0] value_size;
		logic [63:0] cas_value;
	} result_beat_t;

endpackage

// ----- hdl/kv_binary_response_deframer.sv -----
// Top level of the binary response deframer: header capture and body byte tagging.
// A byte passes through the input register, then the result register, to the result port.
// Throughput: one byte per cycle while result_stall is low; the parse state
// (phase, header index, body offset) is next-state logic, so bytes never wait on each other.
// Reset (arst_n low, asynchronous): parser returns to header byte 0, all captured
// lengths, CAS and the magic flag clear to zero, and both pipeline stages empty.
module kv_binary_response_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        stream_valid,
	output logic                        stream_stall,
	input  kvbrd_pkg::stream_beat_t     stream_beat,
	output logic                        result_valid,
	input  logic                        result_stall,
	output kvbrd_pkg::result_beat_t     result_beat
);
	import kvbrd_pkg::*;

	// Input register stage.
	logic         valid_s1;
	stream_beat_t beat_s1;

	// Parse state.
	logic [1:0]  phase_q,  phase_n;
	logic [4:0]  hidx_q,   hidx_n;
	logic [31:0] off_q,    off_n;
	logic [15:0] key_q,    key_n;
	logic [7:0]  extras_q, extras_n;
	logic [31:0] body_q,   body_n;
	logic [63:0] cas_q,    cas_n;
	logic        magic_q,  magic_n;

	// Result register stage.
	logic         valid_s2;
	result_beat_t beat_s2;

	logic         adv;
	logic         load_s1;
	logic         step;
	logic [7:0]   b;
	logic [4:0]   body_sh;
	logic [4:0]   cas_sh;
	logic [31:0]  off_plus;
	logic [16:0]  ek_n;
	logic [16:0]  ek_q;
	logic         done;
	logic         lerr;
	result_beat_t res;

	assign adv          = !valid_s2 || !result_stall;
	assign load_s1      = !valid_s1 || adv;
	assign step         = valid_s1 && adv;
	assign stream_stall = !load_s1;
	assign result_valid = valid_s2;
	assign result_beat  = beat_s2;

	assign b        = beat_s1.data_byte;
	assign body_sh  = HDR_BODY_LO - hidx_q;
	assign cas_sh   = HDR_LAST - hidx_q;
	assign off_plus = off_q + 32'd1;
	assign ek_q     = {1'b0, key_q} + {9'd0, extras_q};
	assign ek_n     = {1'b0, key_n} + {9'd0, extras_n};

	always_comb begin
		phase_n  = phase_q;
		hidx_n   = hidx_q;
		off_n    = off_q;
		key_n    = key_q;
		extras_n = extras_q;
		body_n   = body_q;
		cas_n    = cas_q;
		magic_n  = magic_q;
		done     = 1'b0;
		lerr     = 1'b0;
		unique case (phase_q) inside
			SEG_HEADER: begin
				if (hidx_q == HDR_MAGIC) begin
					magic_n = (b != RESPONSE_MAGIC);
				end else if (hidx_q == HDR_KEY_HI) begin
					key_n = {b, 8'h00};
				end else if (hidx_q == HDR_KEY_LO) begin
					key_n = {key_q[15:8], b};
				end else if (hidx_q == HDR_EXTRAS) begin
					extras_n = b;
				end else if (hidx_q == HDR_BODY_HI) begin
					body_n = {b, 24'h000000};
				end else if (hidx_q > HDR_BODY_HI && hidx_q <= HDR_BODY_LO) begin
					body_n = body_q | ({24'h000000, b} << {body_sh[1:0], 3'b000});
				end else if (hidx_q == HDR_CAS_HI) begin
					cas_n = {b, 56'h0};
				end else if (hidx_q > HDR_CAS_HI && hidx_q <= HDR_LAST) begin
					cas_n = cas_q | ({56'h0, b} << {cas_sh[2:0], 3'b000});
				end
				if (hidx_q >= HDR_LAST) begin
					hidx_n = 5'd0;
					off_n  = 32'd0;
					if (body_n < {15'd0, ek_n}) begin
						// Body cannot hold extras and key: drop the frame and resync.
						lerr    = 1'b1;
						phase_n = SEG_HEADER;
					end else if (body_n == 32'd0) begin
						done    = 1'b1;
						phase_n = SEG_HEADER;
					end else if (extras_n != 8'd0) begin
						phase_n = SEG_EXTRAS;
					end else if (ek_n != 17'd0) begin
						phase_n = SEG_KEY;
					end else begin
						phase_n = SEG_VALUE;
					end
				end else begin
					hidx_n = hidx_q + 5'd1;
				end
			end
			SEG_EXTRAS, SEG_KEY, SEG_VALUE: begin
				if (off_plus == body_q) begin
					done    = 1'b1;
					phase_n = SEG_HEADER;
					hidx_n  = 5'd0;
					off_n   = 32'd0;
				end else begin
					off_n = off_plus;
					if (off_plus < {24'd0, extras_q}) begin
						phase_n = SEG_EXTRAS;
					end else if (off_plus < {15'd0, ek_q}) begin
						phase_n = SEG_KEY;
					end else begin
						phase_n = SEG_VALUE;
					end
				end
			end
		endcase
	end

	always_comb begin
		res.segment      = phase_q;
		res.payload_byte = b;
		res.frame_done   = done;
		res.truncated    = beat_s1.end_of_data &&
			!(phase_n == SEG_HEADER && hidx_n == 5'd0);
		res.length_error = lerr;
		res.magic_bad    = magic_n;
		res.key_size     = key_n;
		res.extras_size  = extras_n;
		res.value_size   = (body_n >= {15'd0, ek_n}) ? body_n - {15'd0, ek_n} : 32'd0;
		res.cas_value    = cas_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && stream_valid) begin
			beat_s1 <= stream_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= SEG_HEADER;
			hidx_q   <= 5'd0;
			off_q    <= 32'd0;
			key_q    <= 16'd0;
			extras_q <= 8'd0;
			body_q   <= 32'd0;
			cas_q    <= 64'd0;
			magic_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			hidx_q   <= hidx_n;
			off_q    <= off_n;
			key_q    <= key_n;
			extras_q <= extras_n;
			body_q   <= body_n;
			cas_q    <= cas_n;
			magic_q  <= magic_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			beat_s2 <= res;
		end
	end

	// A dropped frame is only ever reported on a header byte, never as complete.
	a_lerr_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.length_error |->
			result_beat.segment == SEG_HEADER && !result_beat.frame_done)
		else $error("length error outside the last header byte");

	// Completing a frame always leaves the parser at the start of the next header.
	a_done_not_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.frame_done |-> !result_beat.truncated)
		else $error("frame reported both complete and truncated");

	// Value bytes can only appear when the header promised a non-empty value.
	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.segment == SEG_VALUE |->
			result_beat.value_size != 32'd0)
		else $error("value byte with zero value length");

	// Extras bytes can only appear when the header gave a non-zero extras length.
	a_extras_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.segment == SEG_EXTRAS |->
			result_beat.extras_size != 8'd0)
		else $error("extras byte with zero extras length");

endmodule
